// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define CHK_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/crc16fc_pkg.sv -----
// Types, constants and the checksum byte update for the CRC16 frame checker.
`timescale 1ns / 1ps

package crc16fc_pkg;

  localparam logic [7:0]  SYNC0      = 8'hF8;
  localparam logic [7:0]  SYNC1      = 8'h55;
  localparam logic [7:0]  SYNC2      = 8'hCE;
  localparam logic [15:0] CHECK_POLY = 16'h1021;
  localparam logic [15:0] CHECK_TOP  = 16'h8000;

  // Position of the first body byte, the minimum frame size and the fixed frame overhead.
  localparam int unsigned BODY_START = 5;
  localparam int unsigned MIN_BYTES  = 6;
  localparam int unsigned OVERHEAD   = 7;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CHECK_ERR  = 3'd1,
    ST_START_ERR  = 3'd2,
    ST_PROTO_ERR  = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] body_length;
    logic [7:0]  command_code;
    logic [15:0] computed_check;
  } result_t;

  // Non-direct byte update: crc' = T(crc >> 8) ^ (crc << 8) ^ b.
  function automatic logic [15:0] check_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic [15:0] t;
    acc = 16'h0000;
    t   = {crc[15:8], 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (((t ^ acc) & CHECK_TOP) != 16'h0000) begin
        acc = {acc[14:0], 1'b0} ^ CHECK_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
      t = {t[14:0], 1'b0};
    end
    return acc ^ {crc[7:0], 8'h00} ^ {8'h00, b};
  endfunction

endpackage

// ----- rtl/crc16fc_out_buf.sv -----
// Two-entry output buffer (output register plus skid entry) for verdicts.
`timescale 1ns / 1ps

module crc16fc_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  crc16fc_pkg::result_t push_data,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crc16fc_pkg::result_t out_data
);
  import crc16fc_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop      = main_valid && out_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        main_data  <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
        main_data  <= push_data;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

// ----- rtl/crc16_frame_checker_top.sv -----
// Top level of the CRC16 framed packet checker.
`timescale 1ns / 1ps

// Checks a received buffer streamed one byte per transfer, with end_of_buffer
// set on the last byte. Exactly one verdict transfer follows each buffer; it
// is offered from the cycle after its last byte is taken, or once older
// verdicts ahead of it have gone out. Other bytes give no result. The
// verdict order is: first byte not F8 -> protocol mismatch (3); under 6 bytes
// -> incomplete (4); header not F8 55 CE -> start error (2); fewer than
// body_length + 7 bytes -> incomplete (4); else the CRC over the body bytes
// (poly 1021, init 0, byte XORed into the low end) is compared with the last
// two bytes, low first: ok (0) or checksum error (1). body_length,
// command_code and computed_check are reported with every verdict; fields
// not yet received read as zero. Throughput is one byte per clock: the frame
// state and the byte-wide CRC update sit in one stage between the input
// transfer and the verdict register. in_ready drops only while two verdicts
// are waiting in the two-entry output buffer. State clears after each
// verdict. COUNT_WIDTH sizes the saturating byte counter.

module crc16_frame_checker_top #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] body_length,
  output logic [7:0]  command_code,
  output logic [15:0] computed_check
);
  import crc16fc_pkg::*;

  localparam int PW = COUNT_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Frame state
  logic [COUNT_WIDTH-1:0] byte_count;
  logic [7:0]             first_byte;
  logic                   header_ok;
  logic [15:0]            length_reg;
  logic [7:0]             command_reg;
  logic [15:0]            check_reg;
  logic [7:0]             prev_byte;

  logic [COUNT_WIDTH-1:0] byte_count_next;
  logic [7:0]             first_byte_next;
  logic                   header_ok_next;
  logic [15:0]            length_reg_next;
  logic [7:0]             command_reg_next;
  logic [15:0]            check_reg_next;

  logic          accept;
  logic          in_body;
  logic [PW-1:0] total;
  logic [PW-1:0] body_end;
  logic [PW-1:0] need_len;
  result_t       verdict;
  result_t       out_data;
  logic          can_push;

  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;

  always_comb begin
    first_byte_next  = first_byte;
    header_ok_next   = header_ok;
    length_reg_next  = length_reg;
    command_reg_next = command_reg;

    // header, length and command capture by byte position
    if (byte_count == COUNT_WIDTH'(0)) begin
      first_byte_next = data_byte;
      if (data_byte != SYNC0) header_ok_next = 1'b0;
    end
    if (byte_count == COUNT_WIDTH'(1) && data_byte != SYNC1) header_ok_next = 1'b0;
    if (byte_count == COUNT_WIDTH'(2) && data_byte != SYNC2) header_ok_next = 1'b0;
    if (byte_count == COUNT_WIDTH'(3)) length_reg_next[7:0]  = data_byte;
    if (byte_count == COUNT_WIDTH'(4)) length_reg_next[15:8] = data_byte;
    if (byte_count == COUNT_WIDTH'(BODY_START)) command_reg_next = data_byte;

    // body spans positions 5 .. 4 + length
    body_end = PW'(length_reg) + PW'(BODY_START);
    in_body  = (byte_count >= COUNT_WIDTH'(BODY_START)) && (PW'(byte_count) < body_end);
    check_reg_next = in_body ? check_update(check_reg, data_byte) : check_reg;

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + COUNT_WIDTH'(1);

    // verdict, in priority order
    total    = PW'(byte_count) + PW'(1);
    need_len = PW'(length_reg_next) + PW'(OVERHEAD);
    if (first_byte_next != SYNC0) begin
      verdict.status = ST_PROTO_ERR;
    end else if (total < PW'(MIN_BYTES)) begin
      verdict.status = ST_INCOMPLETE;
    end else if (!header_ok_next) begin
      verdict.status = ST_START_ERR;
    end else if (total < need_len) begin
      verdict.status = ST_INCOMPLETE;
    end else if (data_byte != check_reg_next[15:8] || prev_byte != check_reg_next[7:0]) begin
      verdict.status = ST_CHECK_ERR;
    end else begin
      verdict.status = ST_OK;
    end
    verdict.body_length    = length_reg_next;
    verdict.command_code   = command_reg_next;
    verdict.computed_check = check_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_buffer)) begin
      byte_count  <= '0;
      first_byte  <= 8'h00;
      header_ok   <= 1'b1;
      length_reg  <= 16'h0000;
      command_reg <= 8'h00;
      check_reg   <= 16'h0000;
      prev_byte   <= 8'h00;
    end else if (accept) begin
      byte_count  <= byte_count_next;
      first_byte  <= first_byte_next;
      header_ok   <= header_ok_next;
      length_reg  <= length_reg_next;
      command_reg <= command_reg_next;
      check_reg   <= check_reg_next;
      prev_byte   <= data_byte;
    end
  end

  crc16fc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && end_of_buffer),
    .push_data (verdict),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign status         = out_data.status;
  assign body_length    = out_data.body_length;
  assign command_code   = out_data.command_code;
  assign computed_check = out_data.computed_check;

endmodule

// ----- rtl/crc16fc_checker.sv -----
// Port-level assertions for the CRC16 frame checker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc16fc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        end_of_buffer,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] body_length,
  input logic [7:0]  command_code,
  input logic [15:0] computed_check
);

  logic        in_xfer;
  logic        out_stall;
  logic        last_xfer;
  logic        mid_xfer;
  logic [42:0] out_fields;

  assign in_xfer    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign last_xfer  = in_xfer && end_of_buffer;
  assign mid_xfer   = !out_valid && in_xfer && !end_of_buffer;
  assign out_fields = {status, body_length, command_code, computed_check};

  `CHK_ASSERT(a_out_hold, clk, rst, out_stall |=> out_valid, "verdict dropped while stalled")
  `CHK_ASSERT(a_out_stable, clk, rst, out_stall |=> $stable(out_fields), "verdict changed in stall")
  `CHK_NEVER(a_status_code, clk, rst, out_valid && (status > 3'd4), "undefined status code")
  `CHK_ASSERT(a_verdict_src, clk, rst, $rose(out_valid) |-> $past(last_xfer), "orphan verdict")
  `CHK_ASSERT(a_no_spurious, clk, rst, mid_xfer |=> !out_valid, "verdict on a non-final byte")

endmodule

bind crc16_frame_checker_top crc16fc_checker u_crc16fc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .end_of_buffer  (end_of_buffer),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .body_length    (body_length),
  .command_code   (command_code),
  .computed_check (computed_check)
);

// ----- tb/crc16_frame_checker_top_test.sv -----
// Self-checking testbench for the CRC16 framed packet checker.
`timescale 1ns / 1ps

// Byte-stream stimulus goes into a queue that the driver drains at the falling
// edge, one transfer at a time. The monitor samples both handshakes at the
// rising edge. Each accepted byte runs through a cycle-free model of the frame
// state, and every last byte leaves one expected verdict. Each verdict transfer
// is checked field by field against the oldest verdict still owed.

module crc16_frame_checker_top_test;
  import crc16fc_pkg::*;

  localparam int          CNT_W       = 17;
  localparam int unsigned CNT_MAX     = (1 << CNT_W) - 1;
  localparam int          STALL_LIMIT = 1000;  // cycles with no transfer on either side
  localparam int          TAIL_CYCLES = 16;
  localparam int          RAND_BYTES  = 950;
  localparam int          IDLE_PCT    = 24;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } feed_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] body_length;
  logic [7:0]  command_code;
  logic [15:0] computed_check;

  crc16_frame_checker_top #(
    .COUNT_WIDTH(CNT_W)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .body_length   (body_length),
    .command_code  (command_code),
    .computed_check(computed_check)
  );

  always #6 clk = ~clk;

  // Stimulus and scoreboard storage.
  feed_byte_t  byte_feed[$];
  logic [7:0]  frame_buf[$];
  result_t     verdicts_due[$];
  feed_byte_t  next_byte;
  int          error_count = 0;
  int unsigned cyc = 0;
  int          quiet = 0;
  logic        in_fire = 1'b0;

  // Frame state as the checker should see it.
  int unsigned seen_cnt;
  logic [7:0]  lead_byte;
  bit          sync_good;
  logic [15:0] len_acc;
  logic [7:0]  cmd_acc;
  logic [15:0] crc_acc;
  logic [7:0]  last_byte;

  // CRC-CCITT, poly 1021, with the new byte XORed into the low end after the
  // high byte has been pushed through the polynomial.
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = {crc[15:8], 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CHECK_POLY) : {r[14:0], 1'b0};
    end
    return r ^ {crc[7:0], b};
  endfunction

  task automatic clear_frame_state();
    seen_cnt  = 0;
    lead_byte = 8'h00;
    sync_good = 1'b1;
    len_acc   = 16'h0000;
    cmd_acc   = 8'h00;
    crc_acc   = 16'h0000;
    last_byte = 8'h00;
  endtask

  // Update the frame state for one accepted byte; owe a verdict on the last one.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    logic [7:0]  prior;
    result_t     v;
    pos = seen_cnt;
    case (pos)
      0: begin
        lead_byte = b;
        if (b != SYNC0) sync_good = 1'b0;
      end
      1: if (b != SYNC1) sync_good = 1'b0;
      2: if (b != SYNC2) sync_good = 1'b0;
      3: len_acc[7:0] = b;
      4: len_acc[15:8] = b;
      default: ;
    endcase
    if (pos == BODY_START) cmd_acc = b;
    if (pos >= BODY_START && (pos - BODY_START) < len_acc) crc_acc = crc_ccitt_step(crc_acc, b);
    prior     = last_byte;
    last_byte = b;
    if (seen_cnt < CNT_MAX) seen_cnt++;
    if (last) begin
      if (lead_byte != SYNC0)                               v.status = ST_PROTO_ERR;
      else if (pos + 1 < MIN_BYTES)                         v.status = ST_INCOMPLETE;
      else if (!sync_good)                                  v.status = ST_START_ERR;
      else if (pos + 1 < int'(len_acc) + OVERHEAD)          v.status = ST_INCOMPLETE;
      else if (b != crc_acc[15:8] || prior != crc_acc[7:0]) v.status = ST_CHECK_ERR;
      else                                                  v.status = ST_OK;
      v.body_length    = len_acc;
      v.command_code   = cmd_acc;
      v.computed_check = crc_acc;
      verdicts_due.push_back(v);
      clear_frame_state();
    end
  endtask

  // Well-formed frame: sync, length, body, optional trailing bytes, CRC low/high.
  task automatic build_frame(input int unsigned blen, input int unsigned extra);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = 16'h0000;
    frame_buf.delete();
    frame_buf.push_back(SYNC0);
    frame_buf.push_back(SYNC1);
    frame_buf.push_back(SYNC2);
    frame_buf.push_back(blen[7:0]);
    frame_buf.push_back(blen[15:8]);
    for (int unsigned i = 0; i < blen; i++) begin
      b   = 8'($urandom);
      crc = crc_ccitt_step(crc, b);
      frame_buf.push_back(b);
    end
    for (int unsigned i = 0; i < extra; i++) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  // Move the assembled buffer into the feed, flagging its last byte.
  function automatic int ship_frame();
    int n;
    n = frame_buf.size();
    for (int i = 0; i < n; i++) byte_feed.push_back('{frame_buf[i], i == n - 1});
    frame_buf.delete();
    return n;
  endfunction

  // Roughly one cycle in four idles, except in periodic quiet windows.
  function automatic bit take_break();
    if ((cyc % 4000) < 800) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Driver: a new byte only once the previous transfer completed.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (byte_feed.size() != 0 && !take_break()) begin
          next_byte      = byte_feed.pop_front();
          in_valid      <= 1'b1;
          data_byte     <= next_byte.b;
          end_of_buffer <= next_byte.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !take_break();
    end
  end

  // Monitor: predict on input transfers, check on verdict transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) predict_byte(data_byte, end_of_buffer);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict with none outstanding: status %0d", status);
          error_count++;
        end else begin
          automatic result_t v = verdicts_due.pop_front();
          if (status !== v.status) begin
            $error("status: expected %0d, got %0d", v.status, status);
            error_count++;
          end
          if (body_length !== v.body_length) begin
            $error("body_length: expected %0d, got %0d", v.body_length, body_length);
            error_count++;
          end
          if (command_code !== v.command_code) begin
            $error("command_code: expected 0x%02h, got 0x%02h", v.command_code, command_code);
            error_count++;
          end
          if (computed_check !== v.computed_check) begin
            $error("computed_check: expected 0x%04h, got 0x%04h", v.computed_check,
                   computed_check);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: the run is hung if neither side moves before the quiet count reaches STALL_LIMIT.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int          rand_count;
    int unsigned blen;
    int unsigned extra;
    int unsigned pick;
    int unsigned idx;
    int unsigned n;
    logic [15:0] crc_ff;
    clear_frame_state();

    // Directed: lone non-sync byte, lone sync byte, bad third sync byte,
    // empty body, and a one-byte body of all ones.
    byte_feed.push_back('{8'h00, 1'b1});
    byte_feed.push_back('{SYNC0, 1'b1});
    frame_buf = '{SYNC0, SYNC1, 8'h00, 8'h00, 8'h00, 8'h00};
    void'(ship_frame());
    build_frame(0, 0);
    void'(ship_frame());
    build_frame(1, 0);
    crc_ff       = crc_ccitt_step(16'h0000, 8'hFF);
    frame_buf[5] = 8'hFF;
    frame_buf[6] = crc_ff[7:0];
    frame_buf[7] = crc_ff[15:8];
    void'(ship_frame());

    // Random frames: mostly well formed, the rest damaged or noise.
    rand_count = 0;
    while (rand_count < RAND_BYTES) begin
      pick  = $urandom_range(0, 99);
      blen  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      build_frame(blen, extra);
      if (pick < 55) begin
        // intact
      end else if (pick < 67) begin
        // single bit flip in the body, trailing or CRC bytes
        idx = $urandom_range(BODY_START, frame_buf.size() - 1);
        frame_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
      end else if (pick < 77) begin
        idx = $urandom_range(0, 2);
        frame_buf[idx] ^= 8'($urandom_range(1, 255));
      end else if (pick < 89) begin
        n = $urandom_range(1, frame_buf.size() - 1);
        repeat (n) void'(frame_buf.pop_back());
      end else if (pick < 95) begin
        frame_buf[3] = 8'($urandom);
        frame_buf[4] = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00;
      end else begin
        frame_buf.delete();
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
        if ($urandom_range(0, 1) != 0) frame_buf[0] = SYNC0;
      end
      rand_count += ship_frame();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // All bytes transferred, then all verdicts back, then a short tail.
    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
